FILE: hdl/rwva_pkg.sv
package rwva_pkg;

	// Default sizes of the counter store
	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 32;
	localparam int DEF_COUNT_BITS = 4;

	// Register reset values
	localparam int GRID_W_RESET = 80;
	localparam int GRID_H_RESET = 24;

	// Field widths
	localparam int GW_BITS    = 8;
	localparam int GH_BITS    = 6;
	localparam int MODE_BITS  = 2;
	localparam int SYM_BITS   = 7;
	localparam int WX_BITS    = 7;
	localparam int WY_BITS    = 5;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	// Position arithmetic covers the largest grid dimension plus a carry bit
	localparam int POS_BITS   = 11;
	// Product of the two grid registers, and the step counter below it
	localparam int PROD_BITS  = GW_BITS + GH_BITS;
	localparam int STEP_BITS  = PROD_BITS - 1;
	localparam int BUDG_BITS  = PROD_BITS + 2;
	// Widest counter handed to the symbol lookup
	localparam int CNT_MAX_BITS = 16;

	// Input modes
	localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_STEP  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd2;

	// Register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Symbol table
	localparam int LEVELS = 14;
	localparam logic [SYM_BITS-1:0] CH_SPACE = 7'h20;
	localparam logic [SYM_BITS-1:0] LEVEL_CHARS [LEVELS] = '{
		7'h2E, 7'h6F, 7'h2B, 7'h3D, 7'h2A, 7'h42, 7'h4F,
		7'h58, 7'h40, 7'h25, 7'h26, 7'h23, 7'h2F, 7'h5E
	};

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} ctl_state_t;

	// Map a visit count to its symbol
	function automatic logic [SYM_BITS-1:0] symbol_of(input logic [CNT_MAX_BITS-1:0] cnt);
		logic [SYM_BITS-1:0] sym;
		logic [CNT_MAX_BITS-1:0] idx;
		idx = cnt - CNT_MAX_BITS'(1);
		if (cnt == '0) begin
			sym = CH_SPACE;
		end else if (cnt > CNT_MAX_BITS'(LEVELS)) begin
			sym = LEVEL_CHARS[LEVELS-1];
		end else begin
			sym = LEVEL_CHARS[idx[3:0]];
		end
		return sym;
	endfunction

	// Move one position along an axis, bounce off an edge, clamp into 0..lim-1
	function automatic logic [POS_BITS-1:0] axis_move(input logic [POS_BITS-1:0] pos,
			input logic [POS_BITS-1:0] lim, input logic fwd);
		logic [POS_BITS-1:0] last;
		logic [POS_BITS-1:0] res;
		last = lim - POS_BITS'(1);
		if (fwd) begin
			if (pos < last) begin
				res = pos + POS_BITS'(1);
			end else if (pos == '0) begin
				res = '0;
			end else if (pos - POS_BITS'(1) > last) begin
				res = last;
			end else begin
				res = pos - POS_BITS'(1);
			end
		end else begin
			if (pos != '0 && pos <= lim) begin
				res = pos - POS_BITS'(1);
			end else if (pos + POS_BITS'(1) > last) begin
				res = last;
			end else begin
				res = pos + POS_BITS'(1);
			end
		end
		return res;
	endfunction

endpackage

FILE: hdl/random_walk_visit_art.sv
// Items pass from stage one (registered memory read) to the result register when
// the output is not stalled. Throughput: one item per cycle without stalls; each walk
// step is a read-modify-write of one visit-memory counter (registered read), forwarded
// when the next item hits the same entry. A clear item and reset each start a sweep
// that zeroes all 2^(XW+YW) entries (4096 by default), one entry a cycle; input stalls.
// Reset: grid 80 x 24, walker at the grid center, step count zero.
module random_walk_visit_art
	import rwva_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready,
	// input items
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [MODE_BITS-1:0] mode,
	input  logic [1:0]           step_choice,
	input  logic [WX_BITS-1:0]   read_x,
	input  logic [WY_BITS-1:0]   read_y,
	// result items
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SYM_BITS-1:0]  symbol,
	output logic [WX_BITS-1:0]   walker_x,
	output logic [WY_BITS-1:0]   walker_y,
	output logic                 walk_done
);

	localparam int XW        = $clog2(MAX_WIDTH);
	localparam int YW        = $clog2(MAX_HEIGHT);
	localparam int AW        = XW + YW;
	localparam int MEM_DEPTH = 1 << AW;
	localparam int RST_COL   = (GRID_W_RESET < MAX_WIDTH ? GRID_W_RESET : MAX_WIDTH) / 2;
	localparam int RST_ROW   = (GRID_H_RESET < MAX_HEIGHT ? GRID_H_RESET : MAX_HEIGHT) / 2;

	// configuration registers
	logic [GW_BITS-1:0] grid_width_q;
	logic [GH_BITS-1:0] grid_height_q;

	// walker state
	logic [XW-1:0]        col_q;
	logic [YW-1:0]        row_q;
	logic [STEP_BITS-1:0] steps_q;

	// control
	ctl_state_t    state_q, state_d;
	logic [AW-1:0] clr_addr_q;
	logic          clr_we;
	logic          s1_valid_q;
	logic          out_valid_q;

	// stage one payload
	logic                  s1_wr_s1;
	logic                  s1_rd_s1;
	logic                  s1_taken_s1;
	logic [AW-1:0]         addr_s1;
	logic                  fwd_s1;
	logic [COUNT_BITS-1:0] fwd_cnt_s1;

	// memory
	logic [COUNT_BITS-1:0] count_mem [MEM_DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic [AW-1:0]         mem_raddr;

	// datapath
	logic                  accept;
	logic                  s1_adv;
	logic                  step_we;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic [COUNT_BITS-1:0] step_wdata;
	logic [POS_BITS-1:0]   eff_w, eff_h;
	logic [PROD_BITS-1:0]  cells;
	logic [BUDG_BITS-1:0]  need;
	logic                  done_now;
	logic                  in_grid;
	logic                  rd_in_range;
	logic                  step_taken;
	logic [POS_BITS-1:0]   col_move, row_move;

	// ---------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GW_BITS'(GRID_W_RESET);
			grid_height_q <= GH_BITS'(GRID_H_RESET);
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_WIDTH:  grid_width_q  <= pwdata[GW_BITS-1:0];
				REG_HEIGHT: grid_height_q <= pwdata[GH_BITS-1:0];
				default:    grid_width_q  <= grid_width_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = APB_DW'(grid_width_q);
			REG_HEIGHT: prdata = APB_DW'(grid_height_q);
			default:    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Grid limits and step budget
	// ---------------------------------------------------------------
	always_comb begin
		if (grid_width_q == '0) begin
			eff_w = POS_BITS'(1);
		end else if (POS_BITS'(grid_width_q) > POS_BITS'(MAX_WIDTH)) begin
			eff_w = POS_BITS'(MAX_WIDTH);
		end else begin
			eff_w = POS_BITS'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			eff_h = POS_BITS'(1);
		end else if (POS_BITS'(grid_height_q) > POS_BITS'(MAX_HEIGHT)) begin
			eff_h = POS_BITS'(MAX_HEIGHT);
		end else begin
			eff_h = POS_BITS'(grid_height_q);
		end
	end

	// steps < cells/3 exactly when 3*(steps+1) <= cells
	assign cells    = PROD_BITS'(eff_w[GW_BITS-1:0]) * PROD_BITS'(eff_h[GH_BITS-1:0]);
	assign need     = (BUDG_BITS'(steps_q) << 1) + BUDG_BITS'(steps_q) + BUDG_BITS'(3);
	assign done_now = need > BUDG_BITS'(cells);

	assign in_grid     = (POS_BITS'(col_q) < eff_w) && (POS_BITS'(row_q) < eff_h);
	assign rd_in_range = (POS_BITS'(read_x) < eff_w) && (POS_BITS'(read_y) < eff_h);
	assign step_taken  = (mode == MODE_STEP) && !done_now;

	assign col_move = axis_move(POS_BITS'(col_q), eff_w, step_choice[0]);
	assign row_move = axis_move(POS_BITS'(row_q), eff_h, step_choice[1]);

	// ---------------------------------------------------------------
	// Handshake
	// ---------------------------------------------------------------
	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = (state_q == ST_CLEAR) || (s1_valid_q && !s1_adv);
	assign accept   = in_valid && !in_stall;

	// ---------------------------------------------------------------
	// Clear sweep control
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		clr_we  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clr_we = 1'b1;
				if (clr_addr_q == {AW{1'b1}}) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (accept && mode == MODE_CLEAR) begin
					state_d = ST_CLEAR;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// sweep address wraps back to zero at the end of each pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (clr_we) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// ---------------------------------------------------------------
	// Walker position and step count, updated at input transfer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= XW'(RST_COL);
			row_q   <= YW'(RST_ROW);
			steps_q <= '0;
		end else if (accept) begin
			if (mode == MODE_CLEAR) begin
				col_q   <= XW'(eff_w >> 1);
				row_q   <= YW'(eff_h >> 1);
				steps_q <= '0;
			end else if (step_taken) begin
				col_q   <= XW'(col_move);
				row_q   <= YW'(row_move);
				steps_q <= steps_q + STEP_BITS'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Visit memory: read at transfer, write back in stage one
	// ---------------------------------------------------------------
	assign cur_cnt    = fwd_s1 ? fwd_cnt_s1 : rdata_q;
	assign step_wdata = (cur_cnt == {COUNT_BITS{1'b1}}) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
	assign step_we    = s1_valid_q && s1_adv && s1_wr_s1;

	assign mem_we    = step_we || clr_we;
	assign mem_waddr = clr_we ? clr_addr_q : addr_s1;
	assign mem_wdata = clr_we ? '0 : step_wdata;
	assign mem_raddr = (mode == MODE_READ) ? {YW'(read_y), XW'(read_x)} : {row_q, col_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			count_mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rdata_q <= count_mem[mem_raddr];
		end
	end

	// ---------------------------------------------------------------
	// Stage one
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// capture forwarding when the write back lands on the entry being read
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_wr_s1    <= step_taken && in_grid;
			s1_rd_s1    <= (mode == MODE_READ) && rd_in_range;
			s1_taken_s1 <= step_taken;
			addr_s1     <= mem_raddr;
			fwd_s1      <= step_we && (addr_s1 == mem_raddr);
			fwd_cnt_s1  <= step_wdata;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// walker registers still hold this item's outcome while it sits in stage one
	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) begin
			symbol    <= s1_rd_s1 ? symbol_of(CNT_MAX_BITS'(cur_cnt)) : '0;
			walker_x  <= WX_BITS'(col_q);
			walker_y  <= WY_BITS'(row_q);
			walk_done <= done_now;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// the sweep owns the write port alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !step_we)
	else $error("step write during clear sweep");

	// no walk step is taken while a sweep runs
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (steps_q == '0))
	else $error("step count moved during clear sweep");

	// a taken step leaves the walker inside the grid
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_taken_s1) |-> in_grid)
	else $error("walker left the grid after a step");
`endif

endmodule

FILE: tb/random_walk_visit_art_tb.sv
module random_walk_visit_art_tb;
	import rwva_pkg::*;

	localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int USEFUL_ITEMS   = 400;
	localparam int CELLS          = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

	// level glyphs: . o + = * B O X @ % & # / ^
	localparam bit [7:0] ART_GLYPHS [0:13] = '{
		8'h2E, 8'h6F, 8'h2B, 8'h3D, 8'h2A, 8'h42, 8'h4F,
		8'h58, 8'h40, 8'h25, 8'h26, 8'h23, 8'h2F, 8'h5E
	};

	typedef struct packed {
		logic [MODE_BITS-1:0] op;
		logic [1:0]           dir;
		logic [WX_BITS-1:0]   rx;
		logic [WY_BITS-1:0]   ry;
	} walk_item_t;

	typedef struct packed {
		logic [SYM_BITS-1:0] sym;
		logic [WX_BITS-1:0]  col;
		logic [WY_BITS-1:0]  row;
		logic                done;
	} walk_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [APB_AW-1:0]    paddr = '0;
	logic [APB_DW-1:0]    pwdata = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [MODE_BITS-1:0] mode = '0;
	logic [1:0]           step_choice = '0;
	logic [WX_BITS-1:0]   read_x = '0;
	logic [WY_BITS-1:0]   read_y = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SYM_BITS-1:0]  symbol;
	logic [WX_BITS-1:0]   walker_x;
	logic [WY_BITS-1:0]   walker_y;
	logic                 walk_done;

	// stimulus waiting for the driver, and predicted results waiting for the DUT
	walk_item_t   walk_items[$];
	walk_result_t walk_results[$];

	// shadow of the grid registers and the walk state
	bit [GW_BITS-1:0]        grid_w_cfg = GW_BITS'(GRID_W_RESET);
	bit [GH_BITS-1:0]        grid_h_cfg = GH_BITS'(GRID_H_RESET);
	bit [DEF_COUNT_BITS-1:0] visits [0:CELLS-1];
	int                      pos_x;
	int                      pos_y;
	int                      steps_made;

	int  err_cnt = 0;
	int  quiet_cycles = 0;
	int  items_seen = 0;
	int  steps_seen = 0;
	int  reads_seen = 0;
	int  grids_set = 0;
	bit  in_taken = 1'b0;
	int  gap_left = 0;
	int  burst_left = 0;
	int  stall_style = 0;
	int  stall_span = 0;
	int  stall_run = 0;
	bit  hold_out;

	random_walk_visit_art dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.step_choice(step_choice),
		.read_x     (read_x),
		.read_y     (read_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.symbol     (symbol),
		.walker_x   (walker_x),
		.walker_y   (walker_y),
		.walk_done  (walk_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_dim(input int v, input int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int clip(input int v, input int lim);
		if (v < 0) return 0;
		if (v > lim - 1) return lim - 1;
		return v;
	endfunction

	function automatic int grid_cols();
		return clamp_dim(int'(grid_w_cfg), DEF_MAX_WIDTH);
	endfunction

	function automatic int grid_rows();
		return clamp_dim(int'(grid_h_cfg), DEF_MAX_HEIGHT);
	endfunction

	function automatic logic [SYM_BITS-1:0] glyph(input bit [DEF_COUNT_BITS-1:0] cnt);
		if (cnt == 0) return CH_SPACE;
		if (int'(cnt) > 14) return ART_GLYPHS[13][SYM_BITS-1:0];
		return ART_GLYPHS[int'(cnt) - 1][SYM_BITS-1:0];
	endfunction

	function automatic void restart_walk();
		foreach (visits[i]) visits[i] = '0;
		pos_x = grid_cols() / 2;
		pos_y = grid_rows() / 2;
		steps_made = 0;
	endfunction

	// apply one item to the shadow walk and queue the result it must produce
	function automatic void advance_walk(input walk_item_t it);
		int ew;
		int eh;
		int dx;
		int dy;
		int idx;
		walk_result_t r;
		ew = grid_cols();
		eh = grid_rows();
		r.sym = '0;
		case (it.op)
			MODE_CLEAR: begin
				restart_walk();
			end
			MODE_STEP: begin
				if (steps_made < ew * eh / 3) begin
					dx = it.dir[0] ? 1 : -1;
					dy = it.dir[1] ? 1 : -1;
					// a walker left outside a shrunk grid is not counted
					if (pos_x < ew && pos_y < eh) begin
						idx = pos_y * DEF_MAX_WIDTH + pos_x;
						if (visits[idx] != '1) visits[idx] = visits[idx] + 1'b1;
					end
					if (pos_x + dx < 0 || pos_x + dx >= ew) dx = -dx;
					if (pos_y + dy < 0 || pos_y + dy >= eh) dy = -dy;
					pos_x = clip(pos_x + dx, ew);
					pos_y = clip(pos_y + dy, eh);
					steps_made++;
				end
			end
			MODE_READ: begin
				if (int'(it.rx) < ew && int'(it.ry) < eh)
					r.sym = glyph(visits[int'(it.ry) * DEF_MAX_WIDTH + int'(it.rx)]);
			end
			default: ;
		endcase
		r.col = pos_x[WX_BITS-1:0];
		r.row = pos_y[WY_BITS-1:0];
		r.done = (steps_made >= ew * eh / 3);
		walk_results.push_back(r);
	endfunction

	function automatic void queue_item(input logic [MODE_BITS-1:0] op, input logic [1:0] dir,
			input int rx, input int ry);
		walk_item_t it;
		it.op = op;
		it.dir = dir;
		it.rx = rx[WX_BITS-1:0];
		it.ry = ry[WY_BITS-1:0];
		walk_items.push_back(it);
	endfunction

	// one register write: setup cycle, then access cycle
	task automatic apb_write(input logic idx, input int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_WIDTH) grid_w_cfg = value[GW_BITS-1:0];
		else grid_h_cfg = value[GH_BITS-1:0];
	endtask

	// wait until all transfers are done and any clear sweep has finished
	task automatic wait_quiet();
		while (walk_items.size() != 0 || in_valid || walk_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic set_grid(input int w, input int h);
		wait_quiet();
		apb_write(REG_WIDTH, w);
		apb_write(REG_HEIGHT, h);
		grids_set++;
	endtask

	// drive input transfers in bursts with random gaps
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (walk_items.size() > 0) begin
				mode <= walk_items[0].op;
				step_choice <= walk_items[0].dir;
				read_x <= walk_items[0].rx;
				read_y <= walk_items[0].ry;
				void'(walk_items.pop_front());
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 15);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// stall the output side in changing styles
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_span = $urandom_range(16, 128);
		end else begin
			stall_span--;
		end
		case (stall_style)
			0: hold_out = 1'b0;
			1: hold_out = ($urandom_range(0, 1) == 1);
			2: hold_out = ($urandom_range(0, 4) == 0);
			default: begin
				if (stall_run > 0) begin
					hold_out = 1'b1;
					stall_run--;
				end else begin
					hold_out = 1'b0;
					stall_run = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
				end
			end
		endcase
		out_stall <= hold_out;
	end

	// check result transfers, then predict for the input transfer of this edge
	always @(posedge clk) begin
		walk_result_t want;
		walk_item_t got_item;
		in_taken = arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (walk_results.size() == 0) begin
				$error("result transfer with no prediction pending");
				err_cnt++;
			end else begin
				want = walk_results.pop_front();
				if (symbol !== want.sym) begin
					$error("symbol: expected %0d, got %0d", want.sym, symbol);
					err_cnt++;
				end
				if (walker_x !== want.col) begin
					$error("walker_x: expected %0d, got %0d", want.col, walker_x);
					err_cnt++;
				end
				if (walker_y !== want.row) begin
					$error("walker_y: expected %0d, got %0d", want.row, walker_y);
					err_cnt++;
				end
				if (walk_done !== want.done) begin
					$error("walk_done: expected %0d, got %0d", want.done, walk_done);
					err_cnt++;
				end
			end
		end
		if (in_taken) begin
			got_item.op = mode;
			got_item.dir = step_choice;
			got_item.rx = read_x;
			got_item.ry = read_y;
			advance_walk(got_item);
			items_seen++;
			if (mode == MODE_STEP) steps_seen++;
			if (mode == MODE_READ) reads_seen++;
		end
		if (in_taken || (out_valid && !out_stall) || (psel && penable && pwrite && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int w;
		int h;
		int ew;
		int eh;
		int bud;
		int n;
		int m;
		int sel;
		int gen_steps;
		int useful;
		bit osc;
		restart_walk();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset grid: center start, each diagonal, reads near the center, at a corner and outside
		queue_item(MODE_READ, 2'd0, 40, 12);
		queue_item(MODE_STEP, 2'd0, 0, 0);
		queue_item(MODE_STEP, 2'd1, 0, 0);
		queue_item(MODE_STEP, 2'd2, 0, 0);
		queue_item(MODE_STEP, 2'd3, 0, 0);
		queue_item(MODE_READ, 2'd0, 39, 11);
		queue_item(MODE_READ, 2'd0, 40, 12);
		queue_item(MODE_READ, 2'd3, 127, 31);
		queue_item(MODE_READ, 2'd0, 79, 23);
		queue_item(MODE_NONE, 2'd3, 127, 31);
		// zero registers clamp to a single cell with no step budget
		set_grid(0, 0);
		queue_item(MODE_CLEAR, 2'd0, 0, 0);
		queue_item(MODE_STEP, 2'd3, 0, 0);
		queue_item(MODE_READ, 2'd0, 0, 0);
		// oversized registers clamp to the full store
		set_grid(255, 63);
		queue_item(MODE_CLEAR, 2'd0, 0, 0);
		queue_item(MODE_STEP, 2'd3, 0, 0);
		queue_item(MODE_READ, 2'd0, 127, 31);
		// one column: both horizontal moves bounce and clamp to zero
		set_grid(1, 63);
		queue_item(MODE_CLEAR, 2'd0, 0, 0);
		queue_item(MODE_STEP, 2'd0, 0, 0);
		queue_item(MODE_STEP, 2'd1, 0, 0);
		queue_item(MODE_READ, 2'd0, 0, 16);
		queue_item(MODE_READ, 2'd0, 1, 0);
		// shrink without clearing: the walker starts outside the grid
		set_grid(4, 4);
		queue_item(MODE_STEP, 2'd3, 0, 0);
		queue_item(MODE_READ, 2'd0, 1, 3);
		w = 4;
		h = 4;
		gen_steps = 0;
		useful = 0;

		// random phases: mostly small grids walked to the end of the budget
		while (useful < USEFUL_ITEMS) begin
			sel = $urandom_range(0, 9);
			osc = 1'b0;
			if (sel == 0) begin
				case ($urandom_range(0, 4))
					0: w = 0;
					1: w = 1;
					2: w = 128;
					3: w = 255;
					default: w = $urandom_range(0, 255);
				endcase
				case ($urandom_range(0, 4))
					0: h = 0;
					1: h = 1;
					2: h = 32;
					3: h = 63;
					default: h = $urandom_range(0, 63);
				endcase
			end else if (sel == 1) begin
				// narrow strip, back and forth: drives counters into saturation
				w = $urandom_range(96, 128);
				h = $urandom_range(1, 2);
				osc = 1'b1;
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 8);
				osc = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 4) != 0 || sel < 2) set_grid(w, h);
			else begin
				w = int'(grid_w_cfg);
				h = int'(grid_h_cfg);
			end
			ew = clamp_dim(w, DEF_MAX_WIDTH);
			eh = clamp_dim(h, DEF_MAX_HEIGHT);
			bud = ew * eh / 3;
			if ($urandom_range(0, 6) != 0) begin
				queue_item(MODE_CLEAR, 2'($urandom_range(0, 3)), $urandom_range(0, 127),
					$urandom_range(0, 31));
				gen_steps = 0;
				useful++;
			end
			n = ((bud > 48) ? 48 : bud) + $urandom_range(0, 3);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					queue_item(MODE_READ, 2'($urandom_range(0, 3)), $urandom_range(0, ew - 1),
						$urandom_range(0, eh - 1));
					useful++;
				end
				queue_item(MODE_STEP, osc ? {1'($urandom_range(0, 1)), k[0]} :
					2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 31));
				if (gen_steps < bud) useful++;
				gen_steps++;
			end
			m = $urandom_range(2, 8);
			for (int k = 0; k < m; k++) begin
				if ($urandom_range(0, 5) == 0)
					queue_item(MODE_READ, 2'($urandom_range(0, 3)), $urandom_range(0, 127),
						$urandom_range(0, 31));
				else if (osc)
					queue_item(MODE_READ, 2'd0, clip(ew / 2 + int'($urandom_range(0, 4)) - 2, ew),
						$urandom_range(0, eh - 1));
				else
					queue_item(MODE_READ, 2'd0, $urandom_range(0, ew - 1),
						$urandom_range(0, eh - 1));
				useful++;
			end
			if ($urandom_range(0, 7) == 0)
				queue_item(MODE_NONE, 2'($urandom_range(0, 3)), $urandom_range(0, 127),
					$urandom_range(0, 31));
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		$display("Run covered %0d items (%0d walk steps, %0d cell reads) over %0d grid settings",
			items_seen, steps_seen, reads_seen, grids_set);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/rwva_pkg.sv
hdl/random_walk_visit_art.sv
tb/random_walk_visit_art_tb.sv
